// ===== rtl/core/mexp32_pkg.sv =====
// ----------------------------------------------------------------------------
// mexp32_pkg
// Types, constants and microcode for the 32-bit modular exponentiation block.
// ----------------------------------------------------------------------------
package mexp32_pkg;

	localparam int FIELD_W        = 32;
	localparam int DATA_WIDTH_DEF = 32;
	localparam int PC_W           = 4;

	typedef struct packed {
		logic [FIELD_W-1:0] base_value;
		logic [FIELD_W-1:0] exponent;
		logic [FIELD_W-1:0] modulus;
	} mexp_req_t;

	typedef struct packed {
		logic [FIELD_W-1:0] power_result;
		logic               zero_modulus_error;
	} mexp_rsp_t;

	// datapath operations
	typedef enum logic [3:0] {
		OP_NOP,
		OP_LOAD,
		OP_CHECK,
		OP_DIV_STEP,
		OP_DIV_DONE,
		OP_MUL_INIT,
		OP_SQ_INIT,
		OP_MUL_STEP,
		OP_ACC_WB,
		OP_BASE_WB,
		OP_RESULT
	} op_t;

	// jump conditions; taken jump goes to target, else fall through
	typedef enum logic [2:0] {
		C_NEVER,
		C_ALWAYS,
		C_NO_REQ,
		C_MOD_ZERO,
		C_CNT_MORE,
		C_EXP_ZERO,
		C_EBIT_CLEAR,
		C_RSP_BUSY
	} cond_t;

	typedef struct packed {
		op_t             op;
		cond_t           cond;
		logic [PC_W-1:0] target;
	} ctrl_word_t;

	// step addresses
	localparam logic [PC_W-1:0] STEP_WAIT     = 4'd0;
	localparam logic [PC_W-1:0] STEP_CHECK    = 4'd1;
	localparam logic [PC_W-1:0] STEP_DIV      = 4'd2;
	localparam logic [PC_W-1:0] STEP_DIV_DONE = 4'd3;
	localparam logic [PC_W-1:0] STEP_EXP_TEST = 4'd4;
	localparam logic [PC_W-1:0] STEP_MUL_INIT = 4'd5;
	localparam logic [PC_W-1:0] STEP_MUL      = 4'd6;
	localparam logic [PC_W-1:0] STEP_ACC_WB   = 4'd7;
	localparam logic [PC_W-1:0] STEP_SQ_INIT  = 4'd8;
	localparam logic [PC_W-1:0] STEP_SQ       = 4'd9;
	localparam logic [PC_W-1:0] STEP_BASE_WB  = 4'd10;
	localparam logic [PC_W-1:0] STEP_RESULT   = 4'd11;
	localparam logic [PC_W-1:0] STEP_TAIL     = 4'd12;

	// control store
	function automatic ctrl_word_t ucode_rom(input logic [PC_W-1:0] pc);
		ctrl_word_t w;
		case (pc)
			STEP_WAIT:     w = '{OP_LOAD,     C_NO_REQ,     STEP_WAIT};
			STEP_CHECK:    w = '{OP_CHECK,    C_MOD_ZERO,   STEP_RESULT};
			STEP_DIV:      w = '{OP_DIV_STEP, C_CNT_MORE,   STEP_DIV};
			STEP_DIV_DONE: w = '{OP_DIV_DONE, C_NEVER,      STEP_WAIT};
			STEP_EXP_TEST: w = '{OP_NOP,      C_EXP_ZERO,   STEP_RESULT};
			STEP_MUL_INIT: w = '{OP_MUL_INIT, C_EBIT_CLEAR, STEP_SQ_INIT};
			STEP_MUL:      w = '{OP_MUL_STEP, C_CNT_MORE,   STEP_MUL};
			STEP_ACC_WB:   w = '{OP_ACC_WB,   C_NEVER,      STEP_WAIT};
			STEP_SQ_INIT:  w = '{OP_SQ_INIT,  C_NEVER,      STEP_WAIT};
			STEP_SQ:       w = '{OP_MUL_STEP, C_CNT_MORE,   STEP_SQ};
			STEP_BASE_WB:  w = '{OP_BASE_WB,  C_ALWAYS,     STEP_EXP_TEST};
			STEP_RESULT:   w = '{OP_RESULT,   C_RSP_BUSY,   STEP_RESULT};
			STEP_TAIL:     w = '{OP_NOP,      C_ALWAYS,     STEP_WAIT};
			default:       w = '{OP_NOP,      C_ALWAYS,     STEP_WAIT};
		endcase
		return w;
	endfunction

endpackage

// ===== rtl/core/modular_exponentiation_32_top.sv =====
// Loads, checks and reduces the base, then for each exponent bit up to the
// highest set bit multiplies (set bit only) and squares, then gives the result
// and returns to idle; a zero modulus goes straight to the result. One item at
// a time; the bit-serial modular product does one add-double per cycle.
// Reset: asynchronous, active low; returns the step address to idle and clears result valid.
// ----------------------------------------------------------------------------
// modular_exponentiation_32_top
// base ^ exponent mod modulus by square and multiply under microcode control.
// ----------------------------------------------------------------------------
module modular_exponentiation_32_top #(
	parameter int DATA_WIDTH = mexp32_pkg::DATA_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// request channel
	input  logic                  req_valid,
	output logic                  req_stall,
	input  mexp32_pkg::mexp_req_t req,
	// response channel
	output logic                  rsp_valid,
	input  logic                  rsp_stall,
	output mexp32_pkg::mexp_rsp_t rsp
);

	localparam int DW    = DATA_WIDTH;
	localparam int FW    = mexp32_pkg::FIELD_W;
	localparam int CNT_W = (DW > 1) ? $clog2(DW) : 1;
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DW - 1);

	// (x + y) mod m for x, y below m; wraps in DW bits, so the result is right even where x + y overflows
	function automatic logic [DW-1:0] add_mod(input logic [DW-1:0] x,
	                                          input logic [DW-1:0] y,
	                                          input logic [DW-1:0] m);
		logic [DW-1:0] gap;
		gap = m - x;
		if (y >= gap) begin
			return x + y - m;
		end
		return x + y;
	endfunction

	// sequencer
	logic [mexp32_pkg::PC_W-1:0] pc_q, pc_next;
	mexp32_pkg::ctrl_word_t      uw;
	logic                        jump;

	// datapath registers
	logic [DW-1:0]    base_q;   // base; dividend shifter during reduction
	logic [DW-1:0]    exp_q;    // exponent, shifted right per bit
	logic [DW-1:0]    mod_q;
	logic [DW-1:0]    acc_q;    // running result
	logic [DW-1:0]    pa_q;     // multiplier bits, LSB first
	logic [DW-1:0]    pb_q;     // multiplicand, doubled each step
	logic [DW-1:0]    pr_q;     // product; remainder during reduction
	logic [CNT_W-1:0] cnt_q;
	logic             err_q;

	logic             rsp_valid_q;
	mexp32_pkg::mexp_rsp_t rsp_q;

	logic [DW-1:0] base_in, exp_in, mod_in, acc_out;
	logic [DW:0]   rem_sh;
	logic [DW:0]   rem_sub;
	logic          req_xfer, rsp_busy;

	// operand widths: fields are masked or zero-extended to the datapath
	generate
		if (DW > FW) begin : g_wide
			assign base_in = {{(DW-FW){1'b0}}, req.base_value};
			assign exp_in  = {{(DW-FW){1'b0}}, req.exponent};
			assign mod_in  = {{(DW-FW){1'b0}}, req.modulus};
			assign acc_out = acc_q;
		end else if (DW == FW) begin : g_equal
			assign base_in = req.base_value;
			assign exp_in  = req.exponent;
			assign mod_in  = req.modulus;
			assign acc_out = acc_q;
		end else begin : g_narrow
			assign base_in = req.base_value[DW-1:0];
			assign exp_in  = req.exponent[DW-1:0];
			assign mod_in  = req.modulus[DW-1:0];
			assign acc_out = acc_q;
		end
	endgenerate

	logic [FW-1:0] result_field;
	generate
		if (DW >= FW) begin : g_res_trunc
			assign result_field = acc_out[FW-1:0];
		end else begin : g_res_ext
			assign result_field = {{(FW-DW){1'b0}}, acc_out};
		end
	endgenerate

	assign uw        = mexp32_pkg::ucode_rom(pc_q);
	assign req_stall = (uw.op != mexp32_pkg::OP_LOAD);
	assign req_xfer  = req_valid && !req_stall;
	assign rsp_busy  = rsp_valid_q && rsp_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// restoring remainder step for the base reduction
	assign rem_sh  = {pr_q, base_q[DW-1]};
	assign rem_sub = rem_sh - {1'b0, mod_q};

	// jump condition and next step
	always_comb begin
		case (uw.cond)
			mexp32_pkg::C_NEVER:      jump = 1'b0;
			mexp32_pkg::C_ALWAYS:     jump = 1'b1;
			mexp32_pkg::C_NO_REQ:     jump = !req_valid;
			mexp32_pkg::C_MOD_ZERO:   jump = (mod_q == '0);
			mexp32_pkg::C_CNT_MORE:   jump = (cnt_q != CNT_LAST);
			mexp32_pkg::C_EXP_ZERO:   jump = (exp_q == '0);
			mexp32_pkg::C_EBIT_CLEAR: jump = !exp_q[0];
			mexp32_pkg::C_RSP_BUSY:   jump = rsp_busy;
			default:                  jump = 1'b1;
		endcase
		pc_next = jump ? uw.target : pc_q + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= mexp32_pkg::STEP_WAIT;
		end else begin
			pc_q <= pc_next;
		end
	end

	// datapath, driven by the current control word
	always_ff @(posedge clk) begin
		case (uw.op)
			mexp32_pkg::OP_LOAD: begin
				if (req_xfer) begin
					base_q <= base_in;
					exp_q  <= exp_in;
					mod_q  <= mod_in;
					pr_q   <= '0;
					cnt_q  <= '0;
				end
			end
			mexp32_pkg::OP_CHECK: begin
				err_q <= (mod_q == '0);
			end
			mexp32_pkg::OP_DIV_STEP: begin
				pr_q   <= rem_sub[DW] ? rem_sh[DW-1:0] : rem_sub[DW-1:0];
				base_q <= base_q << 1;
				cnt_q  <= cnt_q + 1'b1;
			end
			mexp32_pkg::OP_DIV_DONE: begin
				base_q <= pr_q;
				acc_q  <= DW'(1);
			end
			mexp32_pkg::OP_MUL_INIT: begin
				pa_q  <= acc_q;
				pb_q  <= base_q;
				pr_q  <= '0;
				cnt_q <= '0;
			end
			mexp32_pkg::OP_SQ_INIT: begin
				pa_q  <= base_q;
				pb_q  <= base_q;
				pr_q  <= '0;
				cnt_q <= '0;
			end
			mexp32_pkg::OP_MUL_STEP: begin
				if (pa_q[0]) begin
					pr_q <= add_mod(pr_q, pb_q, mod_q);
				end
				pb_q  <= add_mod(pb_q, pb_q, mod_q);
				pa_q  <= pa_q >> 1;
				cnt_q <= cnt_q + 1'b1;
			end
			mexp32_pkg::OP_ACC_WB: begin
				acc_q <= pr_q;
			end
			mexp32_pkg::OP_BASE_WB: begin
				base_q <= pr_q;
				exp_q  <= exp_q >> 1;
			end
			default: begin
			end
		endcase
	end

	// result register: holds one finished result until its transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (uw.op == mexp32_pkg::OP_RESULT && !rsp_busy) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_valid_q && !rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (uw.op == mexp32_pkg::OP_RESULT && !rsp_busy) begin
			rsp_q.power_result       <= err_q ? '0 : result_field;
			rsp_q.zero_modulus_error <= err_q;
		end
	end

endmodule
